// ===== design/tpcl_pkg.sv =====
package tpcl_pkg;

    localparam int HITS_W = 16;
    localparam logic [HITS_W-1:0] HITS_MAX = 16'hFFFF;
    localparam logic [HITS_W-1:0] HITS_ONE = 16'd1;

    localparam int CFG_DATA_W = 16;
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_HIT_THRESHOLD = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CAPACITY = 1'b1;

    localparam int CAPACITY_W = 5;
    localparam logic [HITS_W-1:0] THRESHOLD_RESET = 16'd2;
    localparam logic [CAPACITY_W-1:0] CAPACITY_RESET = 5'd16;

    localparam int LOOKUP_KEY_W = 32;
    localparam int POSITION_W = 4;
    localparam int OCCUPANCY_W = 5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_UPDATE
    } t_tpcl_state;

    typedef struct packed {
        logic search;
        logic update;
        logic shift_all;
        logic promote;
        logic hit_write;
    } t_tpcl_ctl;

endpackage

// ===== design/tpcl_cell.sv =====
module tpcl_cell #(
    parameter int IDX = 0,
    parameter int KW = 32,
    parameter int CW = 5,
    parameter int IW = 4
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tpcl_pkg::t_tpcl_ctl         i_ctl,
    input  logic [KW-1:0]               i_search_key,
    input  logic [CW-1:0]               i_used,
    input  logic [tpcl_pkg::HITS_W-1:0] i_hits_new,
    input  logic [KW-1:0]               i_prev_key,
    input  logic [tpcl_pkg::HITS_W-1:0] i_prev_hits,
    input  logic                        i_found,
    input  logic [tpcl_pkg::HITS_W-1:0] i_sel_hits,
    input  logic [IW-1:0]               i_pos,
    input  logic [KW-1:0]               i_last_key,
    input  logic [KW-1:0]               i_second_key,
    input  logic                        i_last_hit,
    output logic [KW-1:0]               o_key,
    output logic [tpcl_pkg::HITS_W-1:0] o_hits,
    output logic                        o_found,
    output logic [tpcl_pkg::HITS_W-1:0] o_sel_hits,
    output logic [IW-1:0]               o_pos,
    output logic [KW-1:0]               o_last_key,
    output logic [KW-1:0]               o_second_key,
    output logic                        o_last_hit
);

    localparam logic [CW-1:0] C_IDX = CW'(IDX);
    localparam logic [CW-1:0] C_LAST = CW'(IDX + 1);
    localparam logic [CW-1:0] C_SECOND = CW'(IDX + 2);
    localparam logic [IW-1:0] C_POS = IW'(IDX);

    logic [KW-1:0]               r_key;
    logic [tpcl_pkg::HITS_W-1:0] r_hits;
    logic                        r_upto;
    logic                        r_sel;

    logic w_occupied;
    logic w_match;
    logic w_here;
    logic w_is_last;
    logic w_is_second;
    logic w_load;

    assign w_occupied  = C_IDX < i_used;
    assign w_match     = w_occupied && (r_key == i_search_key);
    assign w_here      = w_match && !i_found;
    assign w_is_last   = i_used == C_LAST;
    assign w_is_second = i_used == C_SECOND;
    assign w_load      = i_ctl.update && (i_ctl.shift_all || (i_ctl.promote && r_upto));

    assign o_key        = r_key;
    assign o_hits       = r_hits;
    assign o_found      = i_found || w_match;
    assign o_sel_hits   = i_sel_hits | (w_here ? r_hits : '0);
    assign o_pos        = i_pos | (w_here ? C_POS : '0);
    assign o_last_key   = i_last_key | (w_is_last ? r_key : '0);
    assign o_second_key = i_second_key | (w_is_second ? r_key : '0);
    assign o_last_hit   = i_last_hit || (w_here && w_is_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upto <= 1'b0;
            r_sel  <= 1'b0;
        end else if (i_ctl.search) begin
            r_upto <= !i_found;
            r_sel  <= w_here;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_key  <= i_prev_key;
            r_hits <= i_prev_hits;
        end else if (i_ctl.update && i_ctl.hit_write && r_sel) begin
            r_hits <= i_hits_new;
        end
    end

endmodule

// ===== design/threshold_promoted_cache_list_top.sv =====
// Channel        Handshake                    Payload
// lookup in      start, busy                  i_lookup_key
// result out     o_valid (one-cycle strobe)   o_hit, o_promoted, o_entry_hits, o_entry_position,
//                                             o_evicted, o_evicted_key, o_occupancy
// config write   i_cfg_we                     i_cfg_index, i_cfg_data
//
// A transaction is accepted when start is high and busy is low. It goes through S_SEARCH,
// the parallel compare that ripples down the row of cells, then S_UPDATE, the shift or
// counter update, after which its registered result strobes. The next one can be accepted in S_UPDATE.
// Synchronous active-low reset empties the list and restores the register defaults.
// The receiver cannot stall, so the result is never held.
module threshold_promoted_cache_list_top #(
    parameter int DEPTH = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [tpcl_pkg::LOOKUP_KEY_W-1:0]    i_lookup_key,
    input  logic                                 i_cfg_we,
    input  logic [tpcl_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [tpcl_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    output logic                                 o_valid,
    output logic                                 o_hit,
    output logic                                 o_promoted,
    output logic [tpcl_pkg::HITS_W-1:0]          o_entry_hits,
    output logic [tpcl_pkg::POSITION_W-1:0]      o_entry_position,
    output logic                                 o_evicted,
    output logic [tpcl_pkg::LOOKUP_KEY_W-1:0]    o_evicted_key,
    output logic [tpcl_pkg::OCCUPANCY_W-1:0]     o_occupancy
);

    localparam int KW = (KEY_WIDTH < tpcl_pkg::LOOKUP_KEY_W) ? KEY_WIDTH : tpcl_pkg::LOOKUP_KEY_W;
    localparam int CW = $clog2(DEPTH + 2);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW = CW + tpcl_pkg::CAPACITY_W;
    localparam int HW = tpcl_pkg::HITS_W;

    tpcl_pkg::t_tpcl_state r_state;
    tpcl_pkg::t_tpcl_state n_state;
    tpcl_pkg::t_tpcl_ctl   w_ctl;
    logic                  w_accept;

    logic [HW-1:0]                       r_threshold;
    logic [tpcl_pkg::CAPACITY_W-1:0]     r_capacity;
    logic [CW-1:0]                       r_used;
    logic [KW-1:0]                       r_key;
    logic                                r_hit;
    logic                                r_promote;
    logic [HW-1:0]                       r_hits_new;
    logic [IW-1:0]                       r_pos;
    logic [KW-1:0]                       r_ev_cand;

    logic                                r_valid;
    logic                                r_out_hit;
    logic                                r_out_promoted;
    logic [HW-1:0]                       r_out_hits;
    logic [tpcl_pkg::POSITION_W-1:0]     r_out_pos;
    logic                                r_out_evicted;
    logic [tpcl_pkg::LOOKUP_KEY_W-1:0]   r_out_ev_key;
    logic [tpcl_pkg::OCCUPANCY_W-1:0]    r_out_occ;

    logic [KW-1:0] w_key  [DEPTH];
    logic [HW-1:0] w_hits [DEPTH];
    logic          c_found    [DEPTH+1];
    logic [HW-1:0] c_sel_hits [DEPTH+1];
    logic [IW-1:0] c_pos      [DEPTH+1];
    logic [KW-1:0] c_last     [DEPTH+1];
    logic [KW-1:0] c_second   [DEPTH+1];
    logic          c_last_hit [DEPTH+1];

    logic          w_hit_s;
    logic [HW-1:0] w_hits_inc;
    logic          w_promote_s;
    logic [CW-1:0] w_cnt;
    logic [XW-1:0] w_cap_x;
    logic [XW-1:0] w_cap_eff;
    logic          w_evict;
    logic [CW-1:0] w_cnt_fin;
    logic [IW-1:0] w_pos_fin;
    logic [IW+tpcl_pkg::POSITION_W-1:0]     w_pos_ext;
    logic [CW+tpcl_pkg::OCCUPANCY_W-1:0]    w_occ_ext;
    logic [KW+tpcl_pkg::LOOKUP_KEY_W-1:0]   w_ev_ext;

    assign c_found[0]    = 1'b0;
    assign c_sel_hits[0] = '0;
    assign c_pos[0]      = '0;
    assign c_last[0]     = '0;
    assign c_second[0]   = '0;
    assign c_last_hit[0] = 1'b0;

    assign w_ctl.search    = r_state == tpcl_pkg::S_SEARCH;
    assign w_ctl.update    = r_state == tpcl_pkg::S_UPDATE;
    assign w_ctl.shift_all = !r_hit;
    assign w_ctl.promote   = r_promote;
    assign w_ctl.hit_write = r_hit && !r_promote;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [KW-1:0] w_prev_key;
        logic [HW-1:0] w_prev_hits;
        if (g == 0) begin : g_front
            assign w_prev_key  = r_key;
            assign w_prev_hits = r_hits_new;
        end else begin : g_inner
            assign w_prev_key  = w_key[g-1];
            assign w_prev_hits = w_hits[g-1];
        end
        tpcl_cell #(
            .IDX(g),
            .KW (KW),
            .CW (CW),
            .IW (IW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_search_key(r_key),
            .i_used      (r_used),
            .i_hits_new  (r_hits_new),
            .i_prev_key  (w_prev_key),
            .i_prev_hits (w_prev_hits),
            .i_found     (c_found[g]),
            .i_sel_hits  (c_sel_hits[g]),
            .i_pos       (c_pos[g]),
            .i_last_key  (c_last[g]),
            .i_second_key(c_second[g]),
            .i_last_hit  (c_last_hit[g]),
            .o_key       (w_key[g]),
            .o_hits      (w_hits[g]),
            .o_found     (c_found[g+1]),
            .o_sel_hits  (c_sel_hits[g+1]),
            .o_pos       (c_pos[g+1]),
            .o_last_key  (c_last[g+1]),
            .o_second_key(c_second[g+1]),
            .o_last_hit  (c_last_hit[g+1])
        );
    end

    assign w_hit_s     = c_found[DEPTH];
    assign w_hits_inc  = (c_sel_hits[DEPTH] == tpcl_pkg::HITS_MAX) ?
                         c_sel_hits[DEPTH] : c_sel_hits[DEPTH] + HW'(1);
    assign w_promote_s = w_hit_s && (c_pos[DEPTH] != '0) && (w_hits_inc > r_threshold);

    assign w_cnt   = r_hit ? r_used : r_used + CW'(1);
    assign w_cap_x = XW'(r_capacity);
    always_comb begin
        priority if (w_cap_x == '0) begin
            w_cap_eff = XW'(1);
        end else if (w_cap_x > XW'(DEPTH)) begin
            w_cap_eff = XW'(DEPTH);
        end else begin
            w_cap_eff = w_cap_x;
        end
    end
    assign w_evict   = XW'(w_cnt) > w_cap_eff;
    assign w_cnt_fin = w_evict ? w_cnt - CW'(1) : w_cnt;
    assign w_pos_fin = (r_hit && !r_promote) ? r_pos : '0;
    assign w_pos_ext = {{tpcl_pkg::POSITION_W{1'b0}}, w_pos_fin};
    assign w_occ_ext = {{tpcl_pkg::OCCUPANCY_W{1'b0}}, w_cnt_fin};
    assign w_ev_ext  = {{tpcl_pkg::LOOKUP_KEY_W{1'b0}}, (w_evict ? r_ev_cand : '0)};

    always_comb begin
        w_accept = 1'b0;
        n_state  = r_state;
        unique case (r_state)
            tpcl_pkg::S_IDLE, tpcl_pkg::S_UPDATE: begin
                w_accept = start;
                n_state  = start ? tpcl_pkg::S_SEARCH : tpcl_pkg::S_IDLE;
            end
            tpcl_pkg::S_SEARCH: begin
                n_state = tpcl_pkg::S_UPDATE;
            end
            default: begin
                n_state = tpcl_pkg::S_IDLE;
            end
        endcase
    end

    assign busy = r_state == tpcl_pkg::S_SEARCH;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tpcl_pkg::S_IDLE;
            r_used      <= '0;
            r_valid     <= 1'b0;
            r_hit       <= 1'b0;
            r_promote   <= 1'b0;
            r_threshold <= tpcl_pkg::THRESHOLD_RESET;
            r_capacity  <= tpcl_pkg::CAPACITY_RESET;
        end else begin
            r_state <= n_state;
            r_valid <= w_ctl.update;
            if (w_ctl.search) begin
                r_hit     <= w_hit_s;
                r_promote <= w_promote_s;
            end
            if (w_ctl.update) begin
                r_used <= w_cnt_fin;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    tpcl_pkg::CFG_HIT_THRESHOLD: r_threshold <= i_cfg_data;
                    tpcl_pkg::CFG_CAPACITY:
                        r_capacity <= i_cfg_data[tpcl_pkg::CAPACITY_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_key <= i_lookup_key[KW-1:0];
        end
        if (w_ctl.search) begin
            r_hits_new <= w_hit_s ? w_hits_inc : tpcl_pkg::HITS_ONE;
            r_pos      <= c_pos[DEPTH];
            r_ev_cand  <= (w_promote_s && c_last_hit[DEPTH]) ? c_second[DEPTH] : c_last[DEPTH];
        end
        if (w_ctl.update) begin
            r_out_hit      <= r_hit;
            r_out_promoted <= r_promote;
            r_out_hits     <= r_hits_new;
            r_out_pos      <= w_pos_ext[tpcl_pkg::POSITION_W-1:0];
            r_out_evicted  <= w_evict;
            r_out_ev_key   <= w_ev_ext[tpcl_pkg::LOOKUP_KEY_W-1:0];
            r_out_occ      <= w_occ_ext[tpcl_pkg::OCCUPANCY_W-1:0];
        end
    end

    assign o_valid          = r_valid;
    assign o_hit            = r_out_hit;
    assign o_promoted       = r_out_promoted;
    assign o_entry_hits     = r_out_hits;
    assign o_entry_position = r_out_pos;
    assign o_evicted        = r_out_evicted;
    assign o_evicted_key    = r_out_ev_key;
    assign o_occupancy      = r_out_occ;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy did not follow an accepted transaction");

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##3 o_valid)
        else $error("result strobe missing three cycles after accept");

    a_promote_front: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_promoted |-> o_hit && o_entry_position == '0)
        else $error("promoted entry not reported at the front");

    a_miss_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_hit |-> o_entry_hits == tpcl_pkg::HITS_ONE && o_entry_position == '0)
        else $error("inserted entry not reported at the front with one hit");

endmodule
